/* hdl/ped_pkg.sv */
// Shared types, character constants and the hex digit decoder
// for the percent-escape decoder. No dependencies.
package ped_pkg;

   localparam logic [7:0] ESC_RESET = 8'd37;   // '%'
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [3:0] TEN       = 4'd10;
   localparam int         NUM_SLOTS = 3;       // most bytes one request can produce

   typedef struct packed {
      logic       valid;
      logic [3:0] nib;
   } hex_type;

   // bytes decoded from one request, slot 0 goes out first
   typedef struct packed {
      logic [NUM_SLOTS-1:0][7:0] data;
      logic [1:0]                cnt;
      logic                      last;
   } group_type;

   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.nib   = 4'd0;
      if (c >= CH_0 && c <= CH_9) begin
         h.nib = 4'(c - CH_0);
      end else if (c >= CH_LA && c <= CH_LF) begin
         h.nib = TEN + 4'(c - CH_LA);
      end else if (c >= CH_UA && c <= CH_UF) begin
         h.nib = TEN + 4'(c - CH_UA);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

/* hdl/ped_front.sv */
// Front end: escape-character register, parse state, and per-request
// expansion into a group of up to three bytes. Depends on ped_pkg.
module ped_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [7:0]          csr_escape_char,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output logic                grp_push,
   output ped_pkg::group_type  grp
);

   typedef enum logic [1:0] {
      PH_PLAIN,
      PH_ESC,
      PH_DIGIT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  escape_ff;
   ped_pkg::hex_type hb, hh;

   assign hb = ped_pkg::hex_value(in_byte);
   assign hh = ped_pkg::hex_value(held_ff);

   always_comb begin
      logic [1:0] n;
      n        = 2'd0;
      grp.data = '0;
      phase_in = PH_PLAIN;
      held_in  = held_ff;
      case (phase_ff)
         PH_ESC: begin
            if (hb.valid) begin
               held_in  = in_byte;
               phase_in = PH_DIGIT;
            end else begin
               grp.data[n] = escape_ff;
               n = n + 2'd1;
               if (in_byte == escape_ff) begin
                  phase_in = PH_ESC;
               end else begin
                  grp.data[n] = in_byte;
                  n = n + 2'd1;
               end
            end
         end
         PH_DIGIT: begin
            if (hb.valid) begin
               grp.data[n] = {hh.nib, hb.nib};
               n = n + 2'd1;
            end else begin
               // held digit is retried as plain text; it only restarts an
               // escape when it equals the escape char, and then fails again
               grp.data[n] = escape_ff;
               n = n + 2'd1;
               grp.data[n] = (held_ff == escape_ff) ? escape_ff : held_ff;
               n = n + 2'd1;
               if (in_byte == escape_ff) begin
                  phase_in = PH_ESC;
               end else begin
                  grp.data[n] = in_byte;
                  n = n + 2'd1;
               end
            end
         end
         default: begin
            if (in_byte == escape_ff) begin
               phase_in = PH_ESC;
            end else begin
               grp.data[n] = in_byte;
               n = n + 2'd1;
            end
         end
      endcase
      if (in_last) begin
         // flush a pending escape at end of string
         if (phase_in == PH_ESC) begin
            grp.data[n] = escape_ff;
            n = n + 2'd1;
         end else if (phase_in == PH_DIGIT) begin
            grp.data[n] = escape_ff;
            n = n + 2'd1;
            grp.data[n] = held_in;
            n = n + 2'd1;
         end
         phase_in = PH_PLAIN;
         held_in  = 8'd0;
      end
      grp.cnt  = n;
      grp.last = in_last;
   end

   assign grp_push = accept && (grp.cnt != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PLAIN;
         held_ff   <= 8'd0;
         escape_ff <= ped_pkg::ESC_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            held_ff  <= held_in;
         end
         if (csr_we) begin
            escape_ff <= csr_escape_char;
         end
      end
   end

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && in_last) |=> (phase_ff == PH_PLAIN && held_ff == 8'd0))
      else $error("parse state not cleared after end of string");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && in_last) |-> grp_push)
      else $error("final byte produced no output");

   a_digit_is_hex: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGIT) |-> hh.valid)
      else $error("held digit is not a hex character");

endmodule

/* hdl/ped_queue.sv */
// Small register queue of decoded byte groups between front and back.
// Depends on ped_pkg.
module ped_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ped_pkg::group_type  wr_grp,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output ped_pkg::group_type  head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   ped_pkg::group_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_grp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || do_pop))
      else $error("queue overflow");

   a_nonempty_group: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head.cnt != 2'd0))
      else $error("empty group stored in queue");

endmodule

/* hdl/ped_back.sv */
// Back end: walks the bytes of the head group one per pop and marks the
// end-of-string byte. Depends on ped_pkg.
module ped_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  ped_pkg::group_type  head,
   output logic                grp_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_out_last
);

   logic [1:0] idx_ff;
   logic       at_end;

   assign at_end       = (idx_ff == head.cnt - 2'd1);
   assign rsp_empty    = !head_valid;
   assign rsp_out_byte = head.data[idx_ff];
   assign rsp_out_last = head.last && at_end;
   assign grp_pop      = rsp_pop && head_valid && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else if (rsp_pop && head_valid) begin
         idx_ff <= at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head.cnt))
      else $error("byte index beyond group");

endmodule

/* hdl/percent_escape_decoder.sv */
// A request's decoded bytes are registered as a group in the queue. Throughput: one
// request per cycle while each yields at most one byte and rsp_pop keeps up; a request
// yielding several bytes (malformed escape or end-of-string flush) holds the queue head
// until all are popped, absorbed by the QUEUE_DEPTH-group queue before req_full rises.
// Reset (synchronous, active high): queue emptied, parse state plain text,
// escape char back to '%'.
module percent_escape_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       csr_we,
   input  logic [7:0] csr_escape_char
);

   logic               accept;
   logic               grp_push;
   logic               grp_pop;
   logic               head_valid;
   ped_pkg::group_type wr_grp;
   ped_pkg::group_type head;

   assign accept = req_push && !req_full;

   ped_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_escape_char (csr_escape_char),
      .accept          (accept),
      .in_byte         (req_in_byte),
      .in_last         (req_in_last),
      .grp_push        (grp_push),
      .grp             (wr_grp)
   );

   ped_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grp_push),
      .wr_grp     (wr_grp),
      .full       (req_full),
      .pop        (grp_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   ped_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .grp_pop      (grp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule
